/* hdl/aup_pkg.sv */
// Shared types and constants for the alpha un-premultiply pixel core.
package aup_pkg;

    localparam int          FIX_BITS   = 24;
    localparam int          CH_W       = 8;
    localparam int          QUO_W      = FIX_BITS + CH_W;
    localparam int          PROD_W     = QUO_W + CH_W;
    localparam int          NUM_CH     = 3;
    localparam logic [7:0]  FULL_ALPHA = 8'd255;
    localparam logic [QUO_W-1:0]  DIVIDEND = {FULL_ALPHA, {FIX_BITS{1'b0}}};
    localparam logic [PROD_W-1:0] FIX_HALF = PROD_W'(1) << (FIX_BITS - 1);

    // One pixel as it travels down the chain.
    typedef struct packed {
        logic [CH_W-1:0] c2;
        logic [CH_W-1:0] c1;
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] alpha;
        logic            row_end;
    } t_pix;

    // Partial remainder and quotient of the reciprocal division.
    typedef struct packed {
        logic [CH_W-1:0]  rem;
        logic [QUO_W-1:0] quo;
    } t_div;

endpackage

/* hdl/aup_div_cell.sv */
// One restoring-division cell: produces one quotient bit of 255<<24 / alpha.
module aup_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  aup_pkg::t_pix i_pix,
    input  aup_pkg::t_div i_div,
    input  logic          i_num_bit,
    output logic          o_valid,
    input  logic          i_ready,
    output aup_pkg::t_pix o_pix,
    output aup_pkg::t_div o_div
);

    logic                      r_valid;
    aup_pkg::t_pix             r_pix;
    aup_pkg::t_div             r_div;
    aup_pkg::t_div             n_div;
    logic [aup_pkg::CH_W:0]    rem_ext;
    logic [aup_pkg::CH_W:0]    rem_sub;
    logic                      take;

    assign rem_ext = {i_div.rem, i_num_bit};
    assign rem_sub = rem_ext - {1'b0, i_pix.alpha};
    assign take    = (rem_ext >= {1'b0, i_pix.alpha});

    // Without a subtraction the shifted remainder is below alpha and fits a byte.
    always_comb begin
        n_div.rem = take ? rem_sub[aup_pkg::CH_W-1:0] : rem_ext[aup_pkg::CH_W-1:0];
        n_div.quo = {i_div.quo[aup_pkg::QUO_W-2:0], take};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pix <= i_pix;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;
    assign o_div   = r_div;

endmodule

/* hdl/aup_scale.sv */
// Multiplies the colours by the reciprocal, then rounds, saturates and selects.
module aup_scale (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  aup_pkg::t_pix            i_pix,
    input  logic [aup_pkg::QUO_W-1:0] i_scale,
    output logic                     o_valid,
    input  logic                     i_ready,
    output aup_pkg::t_pix            o_pix
);

    localparam int PW = aup_pkg::PROD_W;
    localparam int CW = aup_pkg::CH_W;
    localparam int FB = aup_pkg::FIX_BITS;

    logic                          r_valid_a;
    logic                          ready_a;
    aup_pkg::t_pix                 r_pix_a;
    logic [PW-1:0]                 r_prod [aup_pkg::NUM_CH];
    logic [CW-1:0]                 col_in [aup_pkg::NUM_CH];
    logic                          r_valid_b;
    aup_pkg::t_pix                 r_pix_b;
    aup_pkg::t_pix                 n_pix_b;
    logic [CW-1:0]                 col_out [aup_pkg::NUM_CH];
    logic [CW-1:0]                 col_a [aup_pkg::NUM_CH];
    logic [PW-1:0]                 sum [aup_pkg::NUM_CH];

    assign col_in[0] = i_pix.c0;
    assign col_in[1] = i_pix.c1;
    assign col_in[2] = i_pix.c2;

    assign col_a[0] = r_pix_a.c0;
    assign col_a[1] = r_pix_a.c1;
    assign col_a[2] = r_pix_a.c2;

    // Stage A: one product per colour.
    assign ready_a = !r_valid_b || i_ready;
    assign o_ready = !r_valid_a || ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else if (o_ready) begin
            r_valid_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pix_a <= i_pix;
            for (int k = 0; k < aup_pkg::NUM_CH; k++) begin
                r_prod[k] <= {{(PW-CW){1'b0}}, col_in[k]} *
                             {{(PW-aup_pkg::QUO_W){1'b0}}, i_scale};
            end
        end
    end

    // Stage B: round to nearest, clamp to a byte, and apply the opaque and clear cases.
    always_comb begin
        for (int k = 0; k < aup_pkg::NUM_CH; k++) begin
            sum[k] = r_prod[k] + aup_pkg::FIX_HALF;
            if (r_pix_a.alpha == '0) begin
                col_out[k] = '0;
            end else if (r_pix_a.alpha == aup_pkg::FULL_ALPHA) begin
                col_out[k] = col_a[k];
            end else if (|sum[k][PW-1:FB+CW]) begin
                col_out[k] = {CW{1'b1}};
            end else begin
                col_out[k] = sum[k][FB+CW-1:FB];
            end
        end
        n_pix_b         = r_pix_a;
        n_pix_b.c0      = col_out[0];
        n_pix_b.c1      = col_out[1];
        n_pix_b.c2      = col_out[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_b <= 1'b0;
        end else if (ready_a) begin
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && r_valid_a) begin
            r_pix_b <= n_pix_b;
        end
    end

    assign o_valid = r_valid_b;
    assign o_pix   = r_pix_b;

endmodule

/* hdl/alpha_unpremultiply_pixel_core.sv */
// Top level of the alpha un-premultiply pixel core: division cell chain and scaler.
//
//  Channel   Direction  Payload                              Handshake
//  s_axis    in         tdata: c0, c1, c2, alpha; tlast: row end   tvalid/tready
//  m_axis    out        tdata: s0, s1, s2, alpha; tlast: row end   tvalid/tready
//
// One item per cycle is accepted and delivered while the output does not stall. There
// are 32 division cells, each forming one bit of the reciprocal, then a multiply stage
// and a rounding stage. Every stage has its own valid bit, so empty slots close up
// when the output stalls and new items are taken while a result waits. Synchronous
// active-low reset empties the chain; no payload is cleared.
module alpha_unpremultiply_pixel_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [7:0] color_zero, [15:8] color_one,
                                       // [23:16] color_two, [31:24] alpha_in
    input  logic        s_axis_tlast,  // row_end_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] straight_zero, [15:8] straight_one,
                                       // [23:16] straight_two, [31:24] alpha_out
    output logic        m_axis_tlast   // row_end_out
);

    localparam int STEPS = aup_pkg::QUO_W;

    logic          cell_valid [STEPS+1];
    logic          cell_ready [STEPS+1];
    aup_pkg::t_pix cell_pix   [STEPS+1];
    aup_pkg::t_div cell_div   [STEPS+1];
    aup_pkg::t_pix out_pix;

    assign cell_valid[0]    = s_axis_tvalid;
    assign s_axis_tready    = cell_ready[0];
    assign cell_pix[0].c0   = s_axis_tdata[7:0];
    assign cell_pix[0].c1   = s_axis_tdata[15:8];
    assign cell_pix[0].c2   = s_axis_tdata[23:16];
    assign cell_pix[0].alpha = s_axis_tdata[31:24];
    assign cell_pix[0].row_end = s_axis_tlast;
    assign cell_div[0]      = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_div
        // The dividend bit brought down at this step, most significant first.
        localparam logic NUM_BIT = aup_pkg::DIVIDEND[STEPS-1-k];

        aup_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (cell_valid[k]),
            .o_ready   (cell_ready[k]),
            .i_pix     (cell_pix[k]),
            .i_div     (cell_div[k]),
            .i_num_bit (NUM_BIT),
            .o_valid   (cell_valid[k+1]),
            .i_ready   (cell_ready[k+1]),
            .o_pix     (cell_pix[k+1]),
            .o_div     (cell_div[k+1])
        );
    end

    aup_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cell_valid[STEPS]),
        .o_ready (cell_ready[STEPS]),
        .i_pix   (cell_pix[STEPS]),
        .i_scale (cell_div[STEPS].quo),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pix   (out_pix)
    );

    assign m_axis_tdata = {out_pix.alpha, out_pix.c2, out_pix.c1, out_pix.c0};
    assign m_axis_tlast = out_pix.row_end;

endmodule

/* hdl/aup_checker.sv */
// Port-level checks for the alpha un-premultiply pixel core, bound to the top level.
module aup_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A result is offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item withdrawn before it was taken");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // Fully transparent pixels leave with all colours cleared.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[31:24] == 8'd0) |-> (m_axis_tdata[23:0] == 24'd0))
        else $error("transparent pixel kept colour");

    // Reset empties the chain.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule

bind alpha_unpremultiply_pixel_core aup_checker u_aup_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
